/* rtl/oram_path_address_generator_macros.svh */
// Assertion macros for the ORAM path address generator.
// No dependencies; included by the modules that carry checks.
`ifndef ORAM_PATH_ADDRESS_GENERATOR_MACROS_SVH
`define ORAM_PATH_ADDRESS_GENERATOR_MACROS_SVH

`ifndef SYNTH
// Clocked property check with the module's own clock and reset.
`define OPAG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be seen at a clock edge.
`define OPAG_ASSERT_NEVER(lbl, cond, msg) \
  `OPAG_ASSERT(lbl, !(cond), msg)
`else
`define OPAG_ASSERT(lbl, prop, msg)
`define OPAG_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

/* rtl/opag_pkg.sv */
// Shared constants and types for the ORAM path address generator.
// No dependencies.
`timescale 1ns / 1ps

package opag_pkg;

  localparam int LEAF_W  = 15;  // leaf number
  localparam int IDX_W   = 16;  // bucket index
  localparam int LEVEL_W = 4;   // tree level
  localparam int CFG_W   = 5;   // tree_levels register

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Classification handed from the front end to the sequencer.
  typedef struct packed {
    logic bad;
    logic root_first;
  } opag_ctl_t;

endpackage

/* rtl/opag_front.sv */
// Front end: tree_levels register, leaf range check and path bit reversal.
// Depends on opag_pkg.
`timescale 1ns / 1ps

module opag_front #(
  parameter int MAX_LEVELS = 16,
  parameter int LVL_W      = 4,
  parameter int REV_W      = 15
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [opag_pkg::CFG_W-1:0] cfg_data_i,
  input  logic [opag_pkg::LEAF_W-1:0] leaf_i,
  input  logic                       root_first_i,
  output opag_pkg::opag_ctl_t        ctl_o,
  output logic [LVL_W-1:0]           depth_o,
  output logic [REV_W-1:0]           rev_o
);
  import opag_pkg::*;

  logic [CFG_W-1:0] levels_q;
  logic [CFG_W:0]   eff_levels;
  logic [CFG_W:0]   depth_full;
  logic             bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      levels_q <= cfg_data_i;
    end
  end

  // clamp to 1 .. MAX_LEVELS
  always_comb begin
    if (levels_q == '0) begin
      eff_levels = (CFG_W+1)'(1);
    end else if (int'(levels_q) > MAX_LEVELS) begin
      eff_levels = (CFG_W+1)'(MAX_LEVELS);
    end else begin
      eff_levels = {1'b0, levels_q};
    end
    depth_full = eff_levels - (CFG_W+1)'(1);
  end

  assign depth_o = depth_full[LVL_W-1:0];

  // leaf >= 2^depth when any bit at or above depth is set
  always_comb begin
    bad = 1'b0;
    for (int j = 0; j < LEAF_W; j++) begin
      if (leaf_i[j] && (j >= int'(depth_o))) bad = 1'b1;
    end
  end

  // rev[i] = leaf[depth-1-i]; level l uses the low l bits of rev
  always_comb begin
    rev_o = '0;
    for (int i = 0; i < REV_W; i++) begin
      for (int j = 0; j < LEAF_W; j++) begin
        if (int'(depth_o) == i + j + 1) rev_o[i] = rev_o[i] | leaf_i[j];
      end
    end
  end

  assign ctl_o.bad        = bad;
  assign ctl_o.root_first = root_first_i;

endmodule

/* rtl/opag_fifo.sv */
// Two-entry queue between the front end and the sequencer.
// No package dependencies.
`timescale 1ns / 1ps

module opag_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o,
  output logic         full_o
);

  localparam int DEPTH = 2;

  logic [W-1:0] mem_q [DEPTH];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == 2'(DEPTH));

endmodule

/* rtl/opag_back.sv */
// Sequencer: walks one path a level per cycle and registers each word.
// Depends on opag_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "oram_path_address_generator_macros.svh"

module opag_back #(
  parameter int MAX_LEVELS = 16,
  parameter int LVL_W      = 4,
  parameter int REV_W      = 15
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  opag_pkg::opag_ctl_t         ctl_i,
  input  logic [LVL_W-1:0]            depth_i,
  input  logic [REV_W-1:0]            rev_i,
  output logic                        pop_o,
  output logic                        valid_o,
  output logic [opag_pkg::IDX_W-1:0]  bucket_index_o,
  output logic [opag_pkg::LEVEL_W-1:0] tree_level_o,
  output logic                        last_o,
  output logic                        bad_leaf_o
);
  import opag_pkg::*;

  localparam int IW = (MAX_LEVELS > IDX_W) ? MAX_LEVELS : IDX_W;
  localparam int LW = (LVL_W > LEVEL_W) ? LVL_W : LEVEL_W;

  logic             active_q;
  opag_ctl_t        ctl_q;
  logic [LVL_W-1:0] depth_q, lvl_q;
  logic [REV_W-1:0] rev_q;
  logic             last_now;

  logic [IW-1:0]    low_mask, idx_full;
  logic [LW-1:0]    lvl_x;

  logic             valid_q, last_q, bad_q;
  logic [IDX_W-1:0] idx_q;
  logic [LEVEL_W-1:0] level_q;

  assign last_now = ctl_q.bad ||
                    (ctl_q.root_first ? (lvl_q == depth_q) : (lvl_q == '0));
  assign pop_o    = !empty_i && (!active_q || last_now);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= pop_o || (active_q && !last_now);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ctl_q   <= ctl_i;
      depth_q <= depth_i;
      rev_q   <= rev_i;
      lvl_q   <= ctl_i.root_first ? '0 : depth_i;
    end else if (active_q) begin
      lvl_q   <= ctl_q.root_first ? lvl_q + LVL_W'(1) : lvl_q - LVL_W'(1);
    end
  end

  // index = 2^l - 1 + low l bits of the reversed path
  always_comb begin
    low_mask = (IW'(1) << lvl_q) - IW'(1);
    idx_full = low_mask + ({{(IW-REV_W){1'b0}}, rev_q} & low_mask);
    lvl_x    = LW'(lvl_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= ctl_q.bad ? '0 : idx_full[IDX_W-1:0];
    level_q <= ctl_q.bad ? '0 : lvl_x[LEVEL_W-1:0];
    last_q  <= last_now;
    bad_q   <= ctl_q.bad;
  end

  assign valid_o        = valid_q;
  assign bucket_index_o = idx_q;
  assign tree_level_o   = level_q;
  assign last_o         = last_q;
  assign bad_leaf_o     = bad_q;

  `OPAG_ASSERT(a_bad_word_shape,
    (valid_o && bad_leaf_o) |-> (last_o && bucket_index_o == '0 && tree_level_o == '0),
    "bad leaf word must be a single zero word")
  `OPAG_ASSERT(a_path_contiguous, (valid_o && !last_o) |=> valid_o,
    "path words must come on consecutive cycles")
  `OPAG_ASSERT(a_level_steps,
    (valid_o && !last_o) |=> (tree_level_o == ($past(tree_level_o) + 4'd1) ||
                              tree_level_o == ($past(tree_level_o) - 4'd1)),
    "level must move by one between path words")

endmodule

/* rtl/oram_path_address_generator.sv */
// Top level of the ORAM path address generator: front end, queue, sequencer.
// Depends on opag_pkg, opag_front, opag_fifo and opag_back.
`timescale 1ns / 1ps
// First word: written to the queue, loaded by the sequencer, then registered at the output.
// Throughput: one word per cycle while paths are pending; a path of L levels gives L words, a bad leaf one.
// The sequencer sets the rate; the two-entry queue lets start be taken while it works.
// busy is high only when the queue is full. The receiver cannot stall; words are strobed.
// Reset clears the queue and sequencer and sets tree_levels to 16.

module oram_path_address_generator #(
  parameter int MAX_LEVELS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration: tree_levels
  input  logic                         cfg_we_i,
  input  logic [opag_pkg::CFG_W-1:0]   cfg_data_i,
  // command
  input  logic                         start,
  output logic                         busy,
  input  logic [opag_pkg::LEAF_W-1:0]  leaf_i,
  input  logic                         root_first_i,
  // result words
  output logic                         valid_o,
  output logic [opag_pkg::IDX_W-1:0]   bucket_index_o,
  output logic [opag_pkg::LEVEL_W-1:0] tree_level_o,
  output logic                         last_o,
  output logic                         bad_leaf_o
);
  import opag_pkg::*;

  // depth = levels - 1 fits LVL_W bits; reversed path holds depth bits
  localparam int LVL_W = (MAX_LEVELS > 2) ? $clog2(MAX_LEVELS) : 1;
  localparam int REV_W = MAX_LEVELS - 1;
  localparam int CTL_W = $bits(opag_ctl_t);
  localparam int ENT_W = CTL_W + LVL_W + REV_W;

  opag_ctl_t        f_ctl, b_ctl;
  logic [LVL_W-1:0] f_depth, b_depth;
  logic [REV_W-1:0] f_rev, b_rev;
  logic [ENT_W-1:0] q_in, q_out;
  logic             push, pop, q_empty, q_full;

  opag_front #(
    .MAX_LEVELS (MAX_LEVELS),
    .LVL_W      (LVL_W),
    .REV_W      (REV_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .leaf_i       (leaf_i),
    .root_first_i (root_first_i),
    .ctl_o        (f_ctl),
    .depth_o      (f_depth),
    .rev_o        (f_rev)
  );

  // a command is taken whenever the queue has room
  assign busy = q_full;
  assign push = start && !q_full;
  assign q_in = {f_ctl, f_depth, f_rev};

  opag_fifo #(
    .W (ENT_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .pop_i   (pop),
    .data_o  (q_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  assign {b_ctl, b_depth, b_rev} = q_out;

  opag_back #(
    .MAX_LEVELS (MAX_LEVELS),
    .LVL_W      (LVL_W),
    .REV_W      (REV_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .ctl_i          (b_ctl),
    .depth_i        (b_depth),
    .rev_i          (b_rev),
    .pop_o          (pop),
    .valid_o        (valid_o),
    .bucket_index_o (bucket_index_o),
    .tree_level_o   (tree_level_o),
    .last_o         (last_o),
    .bad_leaf_o     (bad_leaf_o)
  );

endmodule

/* sim/tb_oram_path_address_generator.sv */
// Testbench for oram_path_address_generator: directed and random leaf paths,
// checked word by word against a predictor of the bit-reversed tree layout.
// Depends on opag_pkg and the RTL of oram_path_address_generator.
`timescale 1ns / 1ps

module tb_oram_path_address_generator;
  import opag_pkg::*;

  localparam int MAX_LEVELS  = 16;
  localparam int CYCLE_LIMIT = 200000;  // far above the slowest correct run
  localparam int SETTLE      = 6;       // cycles past the last word before idle

  // One expected output word.
  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [LEVEL_W-1:0] level;
    logic               last;
    logic               bad;
  } path_word_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 start;
  logic                 busy;
  logic [LEAF_W-1:0]    leaf_i;
  logic                 root_first_i;
  logic                 valid_o;
  logic [IDX_W-1:0]     bucket_index_o;
  logic [LEVEL_W-1:0]   tree_level_o;
  logic                 last_o;
  logic                 bad_leaf_o;

  // Shadow of tree_levels, updated when the write is driven.
  logic [CFG_W-1:0]     levels_shadow;
  // Words predicted for accepted leaves, oldest first.
  path_word_t           path_words_q[$];
  int                   error_count;
  int                   cycle_count;

  oram_path_address_generator #(
    .MAX_LEVELS(MAX_LEVELS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .start         (start),
    .busy          (busy),
    .leaf_i        (leaf_i),
    .root_first_i  (root_first_i),
    .valid_o       (valid_o),
    .bucket_index_o(bucket_index_o),
    .tree_level_o  (tree_level_o),
    .last_o        (last_o),
    .bad_leaf_o    (bad_leaf_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog: a hang or a lost word ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[oram_path_address_generator] ERROR");
      $finish;
    end
  end

  // Level count in effect: 0 acts as 1, anything past the maximum is clamped.
  function automatic int active_levels();
    if (levels_shadow == 0) return 1;
    if (levels_shadow > MAX_LEVELS) return MAX_LEVELS;
    return int'(levels_shadow);
  endfunction

  // Queue the words for one leaf: one index per level, or a single flagged
  // word when the leaf lies past the last leaf of the tree.
  function automatic void predict_path(logic [LEAF_W-1:0] leaf, logic rf);
    int         levels;
    int         depth;
    int         lvl;
    logic [31:0] pos;
    logic [31:0] rev;
    path_word_t w;
    levels = active_levels();
    depth  = levels - 1;
    if (32'(leaf) >= (32'd1 << depth)) begin
      w = '{index: '0, level: '0, last: 1'b1, bad: 1'b1};
      path_words_q = {path_words_q, w};
      return;
    end
    for (int k = 0; k < levels; k++) begin
      lvl = rf ? k : depth - k;
      pos = 32'(leaf) >> (depth - lvl);
      // mirror the low lvl bits of the position
      rev = '0;
      for (int i = 0; i < lvl; i++) rev = (rev << 1) | pos[i];
      w.index = IDX_W'(((32'd1 << lvl) - 1) + rev);
      w.level = LEVEL_W'(lvl);
      w.last  = (k == levels - 1);
      w.bad   = 1'b0;
      path_words_q = {path_words_q, w};
    end
  endfunction

  // Word checker: the block strobes each word for one cycle, no back-pressure.
  always @(posedge clk_i) begin
    path_word_t exp_w;
    if (rst_ni && valid_o) begin
      if (path_words_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word idx=%0d lvl=%0d last=%b bad=%b", $time,
                 bucket_index_o, tree_level_o, last_o, bad_leaf_o);
      end else begin
        exp_w = path_words_q.pop_front();
        if (bucket_index_o !== exp_w.index || tree_level_o !== exp_w.level ||
            last_o !== exp_w.last || bad_leaf_o !== exp_w.bad) begin
          error_count++;
          $display("%0t: mismatch exp idx=%0d lvl=%0d last=%b bad=%b,",
                   $time, exp_w.index, exp_w.level, exp_w.last, exp_w.bad,
                   " got idx=%0d lvl=%0d last=%b bad=%b",
                   bucket_index_o, tree_level_o, last_o, bad_leaf_o);
        end
      end
    end
  end

  // Offer one leaf and hold it until the block takes it. Called at a falling
  // edge, returns at a falling edge; start stays high for back-to-back words.
  task automatic send_leaf(input logic [LEAF_W-1:0] leaf, input logic rf,
                           input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start        <= 1'b1;
    leaf_i       <= leaf;
    root_first_i <= rf;
    do @(posedge clk_i); while (busy);
    predict_path(leaf, rf);
    @(negedge clk_i);
  endtask

  // Stop sending and wait out every pending word, then the SETTLE wait so the
  // sequencer has surely gone quiet.
  task automatic wait_for_idle();
    start <= 1'b0;
    while (path_words_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // Register write, only with the block idle.
  task automatic set_tree_levels(input logic [CFG_W-1:0] value);
    wait_for_idle();
    cfg_we_i      <= 1'b1;
    cfg_data_i    <= value;
    levels_shadow  = value;
    @(negedge clk_i);
    cfg_we_i      <= 1'b0;
    @(negedge clk_i);
  endtask

  // Default of 16 levels: corner leaves in both directions.
  task automatic test_reset_levels();
    send_leaf('0, 1'b0, 0);
    send_leaf('0, 1'b1, 0);
    send_leaf('1, 1'b0, 0);
    send_leaf('1, 1'b1, 0);
    send_leaf(15'h5555, 1'b0, 0);
    send_leaf(15'h2AAA, 1'b1, 0);
  endtask

  // Level counts at and past the ends of the range, including zero.
  task automatic test_level_extremes();
    set_tree_levels(5'd0);   // acts as a single-level tree
    send_leaf('0, 1'b0, 0);
    send_leaf('0, 1'b1, 0);
    send_leaf(15'd1, 1'b0, 0);
    set_tree_levels(5'd1);
    send_leaf('0, 1'b1, 0);
    send_leaf('1, 1'b0, 0);
    set_tree_levels(5'd2);
    send_leaf(15'd1, 1'b0, 0);
    send_leaf(15'd1, 1'b1, 0);
    send_leaf(15'd2, 1'b1, 0);
    set_tree_levels(5'd31);  // clamped to the maximum
    send_leaf('1, 1'b0, 0);
    send_leaf(15'h4001, 1'b1, 0);
    set_tree_levels(5'd17);
    send_leaf(15'h1234, 1'b0, 0);
  endtask

  // Leaves just inside and just outside a mid-size tree.
  task automatic test_bad_leaf();
    set_tree_levels(5'd5);
    send_leaf(15'd15, 1'b0, 0);
    send_leaf(15'd16, 1'b1, 0);
    send_leaf('1, 1'b0, 0);
    send_leaf(15'd0, 1'b1, 0);
  endtask

  // Random leaves under changing level counts. Mostly leaves inside the tree,
  // some beyond it; now and then the sender drains the block completely.
  task automatic test_random_paths(input int count, input int idle_pct);
    int                levels;
    int                pick;
    logic [LEAF_W-1:0] leaf;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        pick = $urandom_range(9);
        unique case (pick)
          0:       set_tree_levels(5'd0);
          1:       set_tree_levels(5'd1);
          2:       set_tree_levels(5'd2);
          3:       set_tree_levels(5'($urandom_range(17, 31)));
          4, 5, 6: set_tree_levels(5'($urandom_range(3, 15)));
          default: set_tree_levels(5'd16);
        endcase
      end
      levels = active_levels();
      if ($urandom_range(99) < 85)
        leaf = LEAF_W'($urandom_range(0, (1 << (levels - 1)) - 1));
      else
        leaf = LEAF_W'($urandom);
      send_leaf(leaf, 1'($urandom), idle_pct);
      if ($urandom_range(49) == 0) wait_for_idle();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = '0;
    start         = 1'b0;
    leaf_i        = '0;
    root_first_i  = 1'b0;
    levels_shadow = CFG_RESET;
    error_count   = 0;
    cycle_count   = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_levels();
    test_level_extremes();
    test_bad_leaf();
    // Sender pacing phases: back to back, mostly idle, lightly idle.
    test_random_paths(160, 0);
    test_random_paths(160, 63);
    test_random_paths(160, 12);

    wait_for_idle();
    repeat (20) @(negedge clk_i);
    if (path_words_q.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected words never arrived", $time, path_words_q.size());
    end
    if (error_count == 0) begin
      $display("[oram_path_address_generator] OK");
    end else begin
      $display("[oram_path_address_generator] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/opag_pkg.sv
rtl/opag_front.sv
rtl/opag_fifo.sv
rtl/opag_back.sv
rtl/oram_path_address_generator.sv
sim/tb_oram_path_address_generator.sv
